@@ rtl/lbfe_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfe_pkg
// shared types and constants of the led blink / fade engine
// ----------------------------------------------------------------------------
`default_nettype none

package lbfe_pkg;

    localparam int CMD_W      = 3;
    localparam int LEVEL_W    = 8;
    localparam int LEN_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 32;
    localparam int DIV_STEPS  = 8;
    localparam int CNT_W      = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORCE_LIT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORCE_DARK = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_DOWN   = 3'd5;

    // run modes
    localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;

    // reset values
    localparam logic [LEN_W-1:0]   DEF_ON_TIME     = 16'd500;
    localparam logic [LEN_W-1:0]   DEF_OFF_TIME    = 16'd500;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN       = 8'd0;

    // full-step clamp of the ramp quotient
    localparam logic [LEVEL_W:0]   QUO_CLAMP       = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_OFFSET,
        ST_MULT,
        ST_PREP,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/lbfe_if.sv @@
// ----------------------------------------------------------------------------
// lbfe_if
// valid/ready channels of the led blink / fade engine
// ----------------------------------------------------------------------------
`default_nettype none

interface lbfe_req_if;
    logic                          valid;
    logic                          ready;
    logic [lbfe_pkg::CMD_W-1:0]    cmd;
    logic [lbfe_pkg::LEVEL_W-1:0]  level_in;

    modport source (output valid, output cmd, output level_in, input ready);
    modport sink   (input valid, input cmd, input level_in, output ready);
endinterface

interface lbfe_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lbfe_pkg::LEVEL_W-1:0]  level;
    logic                          lit;
    logic                          active;

    modport source (output valid, output level, output lit, output active, input ready);
    modport sink   (input valid, input level, input lit, input active, output ready);
endinterface

`default_nettype wire

@@ rtl/led_blink_fade_engine.sv @@
// ----------------------------------------------------------------------------
// led_blink_fade_engine
// led brightness sequencer: blink and linear fade driven by 1 ms tick words
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  ---------------------------------
//  req      in   valid / ready   cmd[2:0], level_in[7:0]
//  rsp      out  valid / ready   level[7:0], lit, active
//  cfg      in   cfg_wr_en       cfg_index[2:0], cfg_data[15:0]
//
//  a full ramp tick (shared multiply, 8-step restoring divide) passes the check,
//  offset, mult, prep, div and apply states; the next word goes in once it is done
//  early ramp exits skip ramp states, ticks with no ramp and other words go to done
//  rst_n clears the sequence state and loads the register defaults at once
//  req.ready is low while a word is in work; a result waits in an output
//  register and a finished word holds in the done state until it frees
//
`default_nettype none

module led_blink_fade_engine #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lbfe_req_if.sink                              req,
    lbfe_rsp_if.source                            rsp,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lbfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lbfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LW = lbfe_pkg::LEVEL_W;
    localparam int NW = lbfe_pkg::LEN_W;
    // compare width wide enough for both the time gap and len * 256
    localparam int CMP_W = (TIME_WIDTH > NW + LW) ? TIME_WIDTH : NW + LW;

    // configuration registers
    logic [NW-1:0]                    on_time_reg;
    logic [NW-1:0]                    off_time_reg;
    logic [LW-1:0]                    bright_high_reg;
    logic [LW-1:0]                    bright_low_reg;
    logic [lbfe_pkg::MODE_W-1:0]      run_mode_reg;
    logic                             fade_down_reg;

    // sequence state
    logic [TIME_WIDTH-1:0]            elapsed_reg;
    logic [TIME_WIDTH-1:0]            phase_end_reg;
    logic                             lit_reg;
    logic                             running_reg;
    logic [LW-1:0]                    level_reg;

    // captured word
    logic [lbfe_pkg::CMD_W-1:0]       cmd_reg;
    logic [LW-1:0]                    level_in_reg;

    // ramp datapath
    logic [TIME_WIDTH-1:0]            gap_reg;      // phase_end - elapsed, then offset magnitude
    logic [NW-1:0]                    len_reg;
    logic [LW-1:0]                    from_reg;
    logic [LW-1:0]                    to_reg;
    logic [LW-1:0]                    step_reg;     // |to - from|
    logic                             neg_reg;      // quotient is subtracted from the start level
    logic [lbfe_pkg::PROD_W-1:0]      prod_reg;
    logic [NW-1:0]                    rem_reg;
    logic [LW-1:0]                    num_reg;
    logic [LW:0]                      quo_reg;
    logic [lbfe_pkg::CNT_W-1:0]       cnt_reg;

    // output register
    logic                             out_valid_reg;
    logic [LW-1:0]                    out_level_reg;
    logic                             out_lit_reg;
    logic                             out_active_reg;

    lbfe_pkg::state_t                 state_reg;
    lbfe_pkg::state_t                 state_next;

    logic                             req_take;
    logic                             out_load;

    // mode decode
    logic                             fading;
    logic                             single;
    logic [NW-1:0]                    len_off;

    // check stage
    logic                             before_end;
    logic                             after_end;

    // offset stage
    logic [TIME_WIDTH-1:0]            len_ext;
    logic                             step_neg;
    logic                             off_neg;

    // multiply stage
    logic [CMP_W-1:0]                 gap_ext;
    logic [CMP_W-1:0]                 full_ext;

    // divider step
    logic [NW:0]                      trial;
    logic                             trial_ge;
    logic [NW:0]                      trial_sub;

    // final add and clamp
    logic signed [LW+1:0]             ramp_sum;
    logic [LW-1:0]                    ramp_level;

    assign fading  = (run_mode_reg == lbfe_pkg::MODE_FADE) ||
                     (run_mode_reg == lbfe_pkg::MODE_SINGLE);
    assign single  = (run_mode_reg == lbfe_pkg::MODE_SINGLE);
    assign len_off = single ? on_time_reg : off_time_reg;

    assign before_end = elapsed_reg < phase_end_reg;
    assign after_end  = elapsed_reg > phase_end_reg;

    assign len_ext  = TIME_WIDTH'(len_reg);
    assign step_neg = to_reg < from_reg;
    assign off_neg  = gap_reg > len_ext;

    assign gap_ext  = CMP_W'(gap_reg);
    assign full_ext = CMP_W'({len_reg, {LW{1'b0}}});

    assign trial     = {rem_reg, num_reg[LW-1]};
    assign trial_ge  = trial >= {1'b0, len_reg};
    assign trial_sub = trial - {1'b0, len_reg};

    always_comb
    begin
        if (neg_reg)
            ramp_sum = $signed({2'b00, from_reg}) - $signed({1'b0, quo_reg});
        else
            ramp_sum = $signed({2'b00, from_reg}) + $signed({1'b0, quo_reg});
        if (ramp_sum < 0)
            ramp_level = lbfe_pkg::LEVEL_MIN;
        else if (ramp_sum > $signed({2'b00, lbfe_pkg::LEVEL_MAX}))
            ramp_level = lbfe_pkg::LEVEL_MAX;
        else
            ramp_level = ramp_sum[LW-1:0];
    end

    // handshakes
    assign req.ready = (state_reg == lbfe_pkg::ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign out_load  = (state_reg == lbfe_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid  = out_valid_reg;
    assign rsp.level  = out_level_reg;
    assign rsp.lit    = out_lit_reg;
    assign rsp.active = out_active_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg     <= lbfe_pkg::DEF_ON_TIME;
            off_time_reg    <= lbfe_pkg::DEF_OFF_TIME;
            bright_high_reg <= lbfe_pkg::LEVEL_MAX;
            bright_low_reg  <= lbfe_pkg::LEVEL_MIN;
            run_mode_reg    <= lbfe_pkg::MODE_PULSE;
            fade_down_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lbfe_pkg::CFG_ON_TIME:     on_time_reg     <= cfg_data[NW-1:0];
                lbfe_pkg::CFG_OFF_TIME:    off_time_reg    <= cfg_data[NW-1:0];
                lbfe_pkg::CFG_BRIGHT_HIGH: bright_high_reg <= cfg_data[LW-1:0];
                lbfe_pkg::CFG_BRIGHT_LOW:  bright_low_reg  <= cfg_data[LW-1:0];
                lbfe_pkg::CFG_RUN_MODE:    run_mode_reg    <= cfg_data[lbfe_pkg::MODE_W-1:0];
                lbfe_pkg::CFG_FADE_DOWN:   fade_down_reg   <= cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbfe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbfe_pkg::ST_IDLE:
            begin
                if (req_take)
                    state_next = lbfe_pkg::ST_EXEC;
            end
            lbfe_pkg::ST_EXEC:
            begin
                if (cmd_reg == lbfe_pkg::CMD_TICK && running_reg)
                    state_next = lbfe_pkg::ST_CHECK;
                else
                    state_next = lbfe_pkg::ST_DONE;
            end
            lbfe_pkg::ST_CHECK:
            begin
                if (fading && before_end)
                    state_next = lbfe_pkg::ST_OFFSET;
                else
                    state_next = lbfe_pkg::ST_DONE;
            end
            lbfe_pkg::ST_OFFSET:
            begin
                // zero length or flat ramp holds the start level
                if (len_reg == '0 || from_reg == to_reg)
                    state_next = lbfe_pkg::ST_DONE;
                else
                    state_next = lbfe_pkg::ST_MULT;
            end
            lbfe_pkg::ST_MULT:
            begin
                if (gap_reg == '0)
                    state_next = lbfe_pkg::ST_DONE;
                else if (gap_ext >= full_ext)
                    state_next = lbfe_pkg::ST_APPLY;
                else
                    state_next = lbfe_pkg::ST_PREP;
            end
            lbfe_pkg::ST_PREP:
            begin
                if (prod_reg >= lbfe_pkg::PROD_W'(full_ext[NW+LW-1:0]))
                    state_next = lbfe_pkg::ST_APPLY;
                else
                    state_next = lbfe_pkg::ST_DIV;
            end
            lbfe_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = lbfe_pkg::ST_APPLY;
            end
            lbfe_pkg::ST_APPLY:
                state_next = lbfe_pkg::ST_DONE;
            lbfe_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = lbfe_pkg::ST_IDLE;
            end
            default:
                state_next = lbfe_pkg::ST_IDLE;
        endcase
    end

    // sequence state, updated by the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            phase_end_reg <= '0;
            lit_reg       <= 1'b0;
            running_reg   <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                lbfe_pkg::ST_EXEC:
                begin
                    unique case (cmd_reg)
                        lbfe_pkg::CMD_TICK:
                            elapsed_reg <= elapsed_reg + 1'b1;
                        lbfe_pkg::CMD_START:
                        begin
                            elapsed_reg <= '0;
                            running_reg <= 1'b1;
                            if (single)
                            begin
                                phase_end_reg <= TIME_WIDTH'(on_time_reg);
                                lit_reg       <= !fade_down_reg;
                                level_reg     <= fade_down_reg ? lbfe_pkg::LEVEL_MIN
                                                               : lbfe_pkg::LEVEL_MAX;
                            end
                            else
                                phase_end_reg <= '0;  // first tick flips the phase
                        end
                        lbfe_pkg::CMD_STOP:
                            running_reg <= 1'b0;
                        lbfe_pkg::CMD_FORCE_LIT:
                        begin
                            level_reg <= level_in_reg;
                            lit_reg   <= 1'b1;
                        end
                        lbfe_pkg::CMD_FORCE_DARK:
                        begin
                            level_reg <= level_in_reg;
                            lit_reg   <= 1'b0;
                        end
                        default: ;  // unused command, state reported as is
                    endcase
                end
                lbfe_pkg::ST_CHECK:
                begin
                    // phase flip once elapsed passes the end
                    if (!(fading && before_end) && after_end)
                    begin
                        if (single)
                            running_reg <= 1'b0;
                        lit_reg <= !lit_reg;
                        if (lit_reg)
                        begin
                            level_reg     <= bright_low_reg;
                            phase_end_reg <= phase_end_reg + TIME_WIDTH'(len_off);
                        end
                        else
                        begin
                            level_reg     <= bright_high_reg;
                            phase_end_reg <= phase_end_reg + TIME_WIDTH'(on_time_reg);
                        end
                    end
                end
                lbfe_pkg::ST_OFFSET:
                begin
                    if (len_reg == '0 || from_reg == to_reg)
                        level_reg <= from_reg;
                end
                lbfe_pkg::ST_MULT:
                begin
                    if (gap_reg == '0)
                        level_reg <= from_reg;
                end
                lbfe_pkg::ST_APPLY:
                    level_reg <= ramp_level;
                default: ;
            endcase
        end
    end

    // word capture and ramp datapath
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg      <= req.cmd;
            level_in_reg <= req.level_in;
        end
        unique case (state_reg)
            lbfe_pkg::ST_CHECK:
            begin
                gap_reg <= phase_end_reg - elapsed_reg;
                if (lit_reg)
                begin
                    len_reg  <= on_time_reg;
                    from_reg <= bright_high_reg;
                    to_reg   <= bright_low_reg;
                end
                else
                begin
                    len_reg  <= len_off;
                    from_reg <= bright_low_reg;
                    to_reg   <= bright_high_reg;
                end
            end
            lbfe_pkg::ST_OFFSET:
            begin
                // offset from phase start: len - gap, negative if gap exceeds len
                gap_reg  <= off_neg ? gap_reg - len_ext : len_ext - gap_reg;
                neg_reg  <= off_neg ^ step_neg;
                step_reg <= step_neg ? from_reg - to_reg : to_reg - from_reg;
            end
            lbfe_pkg::ST_MULT:
            begin
                prod_reg <= lbfe_pkg::PROD_W'(gap_ext[NW+LW-1:0] * step_reg);
                quo_reg  <= lbfe_pkg::QUO_CLAMP;
            end
            lbfe_pkg::ST_PREP:
            begin
                // quotient below 256: top bits of the product are below len
                rem_reg <= prod_reg[NW+LW-1:LW];
                num_reg <= prod_reg[LW-1:0];
                quo_reg <= (prod_reg >= lbfe_pkg::PROD_W'(full_ext[NW+LW-1:0]))
                           ? lbfe_pkg::QUO_CLAMP : '0;
                cnt_reg <= lbfe_pkg::CNT_W'(lbfe_pkg::DIV_STEPS - 1);
            end
            lbfe_pkg::ST_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub[NW-1:0] : trial[NW-1:0];
                num_reg <= {num_reg[LW-2:0], 1'b0};
                quo_reg <= {quo_reg[LW-1:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg  <= level_reg;
            out_lit_reg    <= lit_reg;
            out_active_reg <= running_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lbfe_checker.sv @@
// ----------------------------------------------------------------------------
// lbfe_checker
// port-level checks of the led blink / fade engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lbfe_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [lbfe_pkg::LEVEL_W-1:0]  rsp_level,
    input wire logic                          rsp_lit,
    input wire logic                          rsp_active
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] pend_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
    end

    // one word in work plus one waiting result at most
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two words outstanding");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without a taken word");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("ready right after a word was taken");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) &&
                                    $stable(rsp_lit) && $stable(rsp_active))
        else $error("stalled result changed");

endmodule

bind led_blink_fade_engine lbfe_checker u_lbfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_level  (rsp.level),
    .rsp_lit    (rsp.lit),
    .rsp_active (rsp.active)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the led blink / fade engine: a queue-fed command
// driver, a result monitor and a lamp predictor, run through directed and
// random command streams under several register settings
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lbfe_pkg::CMD_W-1:0]      cmd_t;
    typedef logic [lbfe_pkg::LEVEL_W-1:0]    level_t;
    typedef logic [lbfe_pkg::LEN_W-1:0]      len_t;
    typedef logic [lbfe_pkg::MODE_W-1:0]     mode_t;
    typedef logic [lbfe_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [lbfe_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [31:0]                     ms_t;

    // command codes the block leaves unused
    localparam cmd_t  CMD_SPARE_LO = 3'd5;
    localparam cmd_t  CMD_SPARE_HI = 3'd7;
    // run mode the block treats as plain pulse
    localparam mode_t MODE_SPARE   = 2'd3;

    localparam int IDLE_PCT         = 28;   // idle share of each side, percent
    localparam int CALM_FROM        = 3000; // window with no idling on either side
    localparam int CALM_TO          = 9000;
    localparam int PRESSURE_AT      = 600;  // result words before the long hold
    localparam int PRESSURE_LEN     = 400;  // cycles the receiver holds off
    localparam int PRESSURE_BACKLOG = 8;    // hold starts only with more words queued
    localparam int CYCLE_LIMIT      = 600000;
    localparam int ERR_SHOW         = 100;
    localparam int DRAIN_CYCLES     = 24;
    localparam int RAND_PHASES      = 24;

    typedef struct packed {
        cmd_t   cmd;
        level_t level_in;
    } cmd_word_t;

    typedef struct packed {
        level_t level;
        logic   lit;
        logic   active;
    } lamp_word_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_wr_en;
    cfg_idx_t  cfg_index;
    cfg_word_t cfg_data;

    lbfe_req_if req_ch ();
    lbfe_rsp_if rsp_ch ();

    led_blink_fade_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: registers and sequence state as the block holds them
    // ------------------------------------------------------------------
    bit [lbfe_pkg::LEN_W-1:0]   on_ms     = lbfe_pkg::DEF_ON_TIME;
    bit [lbfe_pkg::LEN_W-1:0]   off_ms    = lbfe_pkg::DEF_OFF_TIME;
    bit [lbfe_pkg::LEVEL_W-1:0] hi_level  = lbfe_pkg::LEVEL_MAX;
    bit [lbfe_pkg::LEVEL_W-1:0] lo_level  = lbfe_pkg::LEVEL_MIN;
    bit [lbfe_pkg::MODE_W-1:0]  mode      = lbfe_pkg::MODE_PULSE;
    bit                         fade_down = 1'b0;

    bit [31:0]                  elapsed_ms = '0;
    bit [31:0]                  end_ms     = '0;
    bit                         lit_now    = 1'b0;
    bit                         run_now    = 1'b0;
    bit [lbfe_pkg::LEVEL_W-1:0] level_now  = '0;

    cmd_word_t  cmd_backlog[$];     // words waiting for the driver
    lamp_word_t due_lamps[$];       // predicted result words, oldest first

    int unsigned cycles     = 0;
    int unsigned words_seen = 0;
    int unsigned errors     = 0;
    int unsigned hold_left  = 0;
    bit          held       = 1'b0;
    cmd_word_t   next_word;

    // linear ramp inside a phase; d is the distance to the phase end
    function automatic level_t ramp_level(bit [31:0] d, len_t len,
                                          level_t from_lv, level_t to_lv);
        longint dl;
        longint m;
        longint qmag;
        bit     neg_off;
        bit     neg;
        int     diff;
        int     ad;
        int     v;
        dl = d;
        if (len == 0)
            return from_lv;
        // offset from the phase start, negative when the length shrank
        if (dl <= longint'(len))
        begin
            m = longint'(len) - dl;
            neg_off = 1'b0;
        end
        else
        begin
            m = dl - longint'(len);
            neg_off = 1'b1;
        end
        diff = int'(to_lv) - int'(from_lv);
        ad = (diff < 0) ? -diff : diff;
        if (ad == 0 || m == 0)
            return from_lv;
        if (m >= longint'(len) * 256)
            qmag = 256;
        else
            qmag = (m * ad) / longint'(len);
        if (qmag > 256)
            qmag = 256;
        neg = neg_off != (diff < 0);
        v = neg ? int'(from_lv) - int'(qmag) : int'(from_lv) + int'(qmag);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[lbfe_pkg::LEVEL_W-1:0];
    endfunction

    // one millisecond tick
    function automatic void advance_ms();
        bit   fading;
        bit   single;
        len_t len_off;
        fading  = (mode == lbfe_pkg::MODE_FADE) || (mode == lbfe_pkg::MODE_SINGLE);
        single  = (mode == lbfe_pkg::MODE_SINGLE);
        len_off = single ? on_ms : off_ms;
        elapsed_ms = elapsed_ms + 1;
        if (!run_now)
            return;
        if (lit_now)
        begin
            if (fading && elapsed_ms < end_ms)
                level_now = ramp_level(end_ms - elapsed_ms, on_ms, hi_level, lo_level);
            if (elapsed_ms > end_ms)
            begin
                if (single)
                    run_now = 1'b0;
                level_now = lo_level;
                lit_now = 1'b0;
                end_ms = end_ms + ms_t'(len_off);
            end
        end
        else
        begin
            if (fading && elapsed_ms < end_ms)
                level_now = ramp_level(end_ms - elapsed_ms, len_off, lo_level, hi_level);
            if (elapsed_ms > end_ms)
            begin
                if (single)
                    run_now = 1'b0;
                level_now = hi_level;
                lit_now = 1'b1;
                end_ms = end_ms + ms_t'(on_ms);
            end
        end
    endfunction

    // apply one accepted command word and queue the lamp state it reports
    function automatic void predict_lamp(cmd_t cmd, level_t lvl);
        case (cmd)
            lbfe_pkg::CMD_TICK:
                advance_ms();
            lbfe_pkg::CMD_START:
            begin
                elapsed_ms = '0;
                run_now = 1'b1;
                if (mode == lbfe_pkg::MODE_SINGLE)
                begin
                    end_ms = ms_t'(on_ms);
                    lit_now = !fade_down;
                    level_now = fade_down ? lbfe_pkg::LEVEL_MIN : lbfe_pkg::LEVEL_MAX;
                end
                else
                    end_ms = '0;
            end
            lbfe_pkg::CMD_STOP:
                run_now = 1'b0;
            lbfe_pkg::CMD_FORCE_LIT:
            begin
                level_now = lvl;
                lit_now = 1'b1;
            end
            lbfe_pkg::CMD_FORCE_DARK:
            begin
                level_now = lvl;
                lit_now = 1'b0;
            end
            default:
                ;
        endcase
        due_lamps.push_back('{level: level_now, lit: lit_now, active: run_now});
    endfunction

    function automatic bit calm_now();
        return cycles >= CALM_FROM && cycles < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // driver: offers backlog words, predicts each one when it is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_lamp(req_ch.cmd, req_ch.level_in);
            // a new word only once the current one is gone
            if (!req_ch.valid || req_ch.ready)
            begin
                if (cmd_backlog.size() != 0
                    && (calm_now() || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_word = cmd_backlog.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.cmd      <= next_word.cmd;
                    req_ch.level_in <= next_word.level_in;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result words, watches the time limit
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            words_seen++;
            if (due_lamps.size() == 0)
            begin
                if (errors < ERR_SHOW)
                    $error("result word with nothing predicted: level %0d lit %0d active %0d",
                           rsp_ch.level, rsp_ch.lit, rsp_ch.active);
                errors++;
            end
            else
            begin
                lamp_word_t want;
                want = due_lamps.pop_front();
                if (rsp_ch.level !== want.level)
                begin
                    if (errors < ERR_SHOW)
                        $error("level: expected %0d, got %0d", want.level, rsp_ch.level);
                    errors++;
                end
                if (rsp_ch.lit !== want.lit)
                begin
                    if (errors < ERR_SHOW)
                        $error("lit: expected %0d, got %0d", want.lit, rsp_ch.lit);
                    errors++;
                end
                if (rsp_ch.active !== want.active)
                begin
                    if (errors < ERR_SHOW)
                        $error("active: expected %0d, got %0d", want.active, rsp_ch.active);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: drives ready, with one long hold-off so the block backs up
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held && words_seen >= PRESSURE_AT
                 && cmd_backlog.size() > PRESSURE_BACKLOG)
        begin
            held <= 1'b1;
            hold_left <= PRESSURE_LEN;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= calm_now() || $urandom_range(99) >= IDLE_PCT;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_word(cmd_t cmd, level_t lvl);
        cmd_backlog.push_back('{cmd: cmd, level_in: lvl});
    endtask

    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            add_word(lbfe_pkg::CMD_TICK, level_t'($urandom_range(255)));
    endtask

    // register write; the predictor copy follows as the write is driven
    task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            lbfe_pkg::CFG_ON_TIME:     on_ms     = val[lbfe_pkg::LEN_W-1:0];
            lbfe_pkg::CFG_OFF_TIME:    off_ms    = val[lbfe_pkg::LEN_W-1:0];
            lbfe_pkg::CFG_BRIGHT_HIGH: hi_level  = val[lbfe_pkg::LEVEL_W-1:0];
            lbfe_pkg::CFG_BRIGHT_LOW:  lo_level  = val[lbfe_pkg::LEVEL_W-1:0];
            lbfe_pkg::CFG_RUN_MODE:    mode      = val[lbfe_pkg::MODE_W-1:0];
            lbfe_pkg::CFG_FADE_DOWN:   fade_down = val[0];
            default:                   ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(len_t on_len, len_t off_len, level_t hi, level_t lo,
                                mode_t run_mode, bit down);
        write_reg(lbfe_pkg::CFG_ON_TIME, cfg_word_t'(on_len));
        write_reg(lbfe_pkg::CFG_OFF_TIME, cfg_word_t'(off_len));
        write_reg(lbfe_pkg::CFG_BRIGHT_HIGH, cfg_word_t'(hi));
        write_reg(lbfe_pkg::CFG_BRIGHT_LOW, cfg_word_t'(lo));
        write_reg(lbfe_pkg::CFG_RUN_MODE, cfg_word_t'(run_mode));
        write_reg(lbfe_pkg::CFG_FADE_DOWN, cfg_word_t'(down));
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || due_lamps.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly short phases so ticks cross many phase ends
    function automatic len_t rand_len();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return len_t'($urandom_range(65535));
        if (r <= 5)
            return len_t'($urandom_range(40, 13));
        return len_t'($urandom_range(12, 1));
    endfunction

    function automatic level_t rand_level();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return lbfe_pkg::LEVEL_MIN;
        if (r == 1)
            return lbfe_pkg::LEVEL_MAX;
        return level_t'($urandom_range(255));
    endfunction

    // random command stream: ticks dominate, starts restart the sequence
    task automatic add_random_words(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_word(lbfe_pkg::CMD_TICK, level_t'($urandom_range(255)));
            else if (pick < 78)
                add_word(lbfe_pkg::CMD_START, level_t'($urandom_range(255)));
            else if (pick < 82)
                add_word(lbfe_pkg::CMD_STOP, level_t'($urandom_range(255)));
            else if (pick < 88)
                add_word(lbfe_pkg::CMD_FORCE_LIT, rand_level());
            else if (pick < 94)
                add_word(lbfe_pkg::CMD_FORCE_DARK, rand_level());
            else if (pick < 97)
                add_word(cmd_t'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                         level_t'($urandom_range(255)));
            else
                add_word(lbfe_pkg::CMD_TICK, level_t'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = lbfe_pkg::CFG_ON_TIME;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tick while stopped, pulse start, forces, spare codes, stop
        add_word(lbfe_pkg::CMD_TICK, lbfe_pkg::LEVEL_MAX);
        add_word(lbfe_pkg::CMD_START, lbfe_pkg::LEVEL_MIN);
        add_ticks(2);                           // first tick flips into the lit phase
        add_word(lbfe_pkg::CMD_FORCE_LIT, lbfe_pkg::LEVEL_MAX);
        add_word(lbfe_pkg::CMD_FORCE_DARK, lbfe_pkg::LEVEL_MIN);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            add_word(cmd_t'(c), level_t'($urandom_range(255)));
        add_word(lbfe_pkg::CMD_STOP, level_t'($urandom_range(255)));
        wait_idle();

        // repeating fade with inverted levels over very short phases
        apply_config(16'd2, 16'd1, lbfe_pkg::LEVEL_MIN, lbfe_pkg::LEVEL_MAX,
                     lbfe_pkg::MODE_FADE, 1'b0);
        add_word(lbfe_pkg::CMD_START, level_t'($urandom_range(255)));
        add_ticks(4);
        wait_idle();

        // long phase, then shrink it mid-phase: ramp offset goes negative
        apply_config(16'd200, 16'd200, lbfe_pkg::LEVEL_MAX, lbfe_pkg::LEVEL_MIN,
                     lbfe_pkg::MODE_FADE, 1'b0);
        add_word(lbfe_pkg::CMD_START, level_t'($urandom_range(255)));
        add_ticks(2);
        wait_idle();
        write_reg(lbfe_pkg::CFG_ON_TIME, 16'd4);
        add_ticks(2);
        wait_idle();

        // single fade starting dark, stops after one flip
        apply_config(16'd2, 16'd9, lbfe_pkg::LEVEL_MAX, lbfe_pkg::LEVEL_MIN,
                     lbfe_pkg::MODE_SINGLE, 1'b1);
        add_word(lbfe_pkg::CMD_START, level_t'($urandom_range(255)));
        add_ticks(3);
        wait_idle();

        // zero phase lengths under the spare run mode
        apply_config('0, '0, lbfe_pkg::LEVEL_MAX, lbfe_pkg::LEVEL_MIN, MODE_SPARE, 1'b0);
        add_word(lbfe_pkg::CMD_START, level_t'($urandom_range(255)));
        add_ticks(2);
        wait_idle();

        // random phases, the first three pinned to the length extremes
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                apply_config(16'd1, 16'd1, lbfe_pkg::LEVEL_MAX, lbfe_pkg::LEVEL_MIN,
                             lbfe_pkg::MODE_FADE, 1'b0);
            else if (p == 1)
                apply_config('1, '1, lbfe_pkg::LEVEL_MIN, lbfe_pkg::LEVEL_MAX,
                             lbfe_pkg::MODE_SINGLE, 1'b0);
            else if (p == 2)
                apply_config('0, '0, rand_level(), rand_level(), lbfe_pkg::MODE_FADE, 1'b1);
            else
                apply_config(rand_len(), rand_len(), rand_level(), rand_level(),
                             mode_t'($urandom_range(3)), 1'($urandom_range(1)));
            add_random_words($urandom_range(95, 60));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_lamps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
